// ----- hw/rtl/mfb_pkg.sv -----
`timescale 1ns / 1ps

package mfb_pkg;

  // frame store geometry
  localparam int unsigned STORE_DEPTH = 512;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned COORD_W     = 8;
  localparam int unsigned PAGE_ROWS   = 8;
  localparam int unsigned BIT_W       = $clog2(PAGE_ROWS);

  // default frame size
  localparam int unsigned DEF_FRAME_WIDTH  = 128;
  localparam int unsigned DEF_FRAME_HEIGHT = 32;

  // command codes
  localparam logic [1:0] CMD_PIXEL = 2'd0;
  localparam logic [1:0] CMD_LINE  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  // status codes
  localparam logic [1:0] STATUS_DONE    = 2'd0;
  localparam logic [1:0] STATUS_OUTSIDE = 2'd1;
  localparam logic [1:0] STATUS_DIAG    = 2'd2;

endpackage

// ----- hw/rtl/mono_framebuffer_pixel_line_engine.sv -----
`timescale 1ns / 1ps

// channel   direction  handshake                  payload
// command   in         in_valid_i / in_ready_o    cmd, x_start, y_start, x_end, y_end,
//                                                 pixel_on, byte_index
// result    out        out_valid_o / out_ready_i  status, read_byte
//
// steps: pixel write reads the byte, then modifies and writes it back; pixel outside
//   frame or diagonal line is answered on acceptance; read byte reads, then answers;
//   line reads and writes back each drawn pixel, steps over skipped ones; clear all
//   takes the word, then clears one byte per cycle; reset: asynchronous, active low;
//   afterwards a clearing pass zeroes the store and no command word is taken until it ends
// stalls: a finished result waits in the output register; a new command is taken
//   meanwhile, and the engine holds its next result until the output register frees up
module mono_framebuffer_pixel_line_engine #(
  parameter int unsigned FRAME_WIDTH  = mfb_pkg::DEF_FRAME_WIDTH,
  parameter int unsigned FRAME_HEIGHT = mfb_pkg::DEF_FRAME_HEIGHT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // command channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   cmd_i,
  input  logic [mfb_pkg::COORD_W-1:0]  x_start_i,
  input  logic [mfb_pkg::COORD_W-1:0]  y_start_i,
  input  logic [mfb_pkg::COORD_W-1:0]  x_end_i,
  input  logic [mfb_pkg::COORD_W-1:0]  y_end_i,
  input  logic                         pixel_on_i,
  input  logic [mfb_pkg::ADDR_W-1:0]   byte_index_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   status_o,
  output logic [7:0]                   read_byte_o
);

  import mfb_pkg::*;

  // width of the page-times-width product and the byte address sum
  localparam int unsigned FwW    = $clog2(FRAME_WIDTH + 1);
  localparam int unsigned PageW  = COORD_W - BIT_W;
  localparam int unsigned ProdW  = PageW + FwW + 1;
  localparam int unsigned CmpW   = COORD_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLR,
    ST_RMW,
    ST_RDB,
    ST_LINE,
    ST_POST
  } state_e;

  state_e state_q, state_d;

  // frame store, one read port and one write port, registered read data
  logic [7:0]        frame_mem [STORE_DEPTH];
  logic [7:0]        rdata_q;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  logic [7:0]        mem_wdata;

  // clearing sweep
  logic [ADDR_W-1:0] clr_cnt_q, clr_cnt_d;
  logic              clr_report_q, clr_report_d;

  // pending read-modify-write
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [BIT_W-1:0]  bit_q, bit_d;
  logic              on_q, on_d;
  logic              line_q, line_d;

  // line walk
  logic               vert_q, vert_d;
  logic [COORD_W-1:0] fixed_q, fixed_d;
  logic [COORD_W-1:0] k_q, k_d;
  logic [COORD_W-1:0] hi_q, hi_d;

  // result held while the output register is busy
  logic [1:0] res_status_q, res_status_d;
  logic [7:0] res_byte_q, res_byte_d;

  // output register
  logic       out_valid_q, out_valid_d;
  logic [1:0] status_q, status_d;
  logic [7:0] read_byte_q, read_byte_d;

  logic       accept;
  logic       slot_free;
  logic       out_load;
  logic       fin;
  logic [1:0] fin_status;
  logic [7:0] fin_byte;

  // pixel address unit, shared by pixel writes and the line walk
  logic [COORD_W-1:0] px, py;
  logic [ProdW-1:0]   pix_prod;
  logic [ProdW-1:0]   pix_sum;
  logic               pix_ok;
  logic [ADDR_W-1:0]  pix_addr;
  logic [7:0]         bit_mask;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;

  always_comb begin
    if (state_q == ST_LINE) begin
      px = vert_q ? fixed_q : k_q;
      py = vert_q ? k_q : fixed_q;
    end else begin
      px = x_start_i;
      py = y_start_i;
    end
  end

  assign pix_prod = ProdW'(py[COORD_W-1:BIT_W]) * ProdW'(FRAME_WIDTH);
  assign pix_sum  = pix_prod + ProdW'(px);
  assign pix_ok   = ({1'b0, px} < CmpW'(FRAME_WIDTH)) &&
                    ({1'b0, py} < CmpW'(FRAME_HEIGHT)) &&
                    (pix_sum < ProdW'(STORE_DEPTH));
  assign pix_addr = pix_sum[ADDR_W-1:0];
  assign bit_mask = 8'(1) << bit_q;

  always_comb begin
    state_d      = state_q;
    clr_cnt_d    = clr_cnt_q;
    clr_report_d = clr_report_q;
    addr_d       = addr_q;
    bit_d        = bit_q;
    on_d         = on_q;
    line_d       = line_q;
    vert_d       = vert_q;
    fixed_d      = fixed_q;
    k_d          = k_q;
    hi_d         = hi_q;
    res_status_d = res_status_q;
    res_byte_d   = res_byte_q;
    out_valid_d  = out_valid_q;
    status_d     = status_q;
    read_byte_d  = read_byte_q;

    mem_we     = 1'b0;
    mem_waddr  = addr_q;
    mem_wdata  = 8'd0;
    mem_raddr  = pix_addr;
    fin        = 1'b0;
    fin_status = STATUS_DONE;
    fin_byte   = 8'd0;
    out_load   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (state_q == ST_IDLE && cmd_i == CMD_READ) begin
          mem_raddr = byte_index_i;
        end
        if (accept) begin
          case (cmd_i)
            CMD_PIXEL: begin
              if (pix_ok) begin
                // byte read is issued now, write-back next cycle
                addr_d  = pix_addr;
                bit_d   = py[BIT_W-1:0];
                on_d    = pixel_on_i;
                line_d  = 1'b0;
                state_d = ST_RMW;
              end else begin
                fin        = 1'b1;
                fin_status = STATUS_OUTSIDE;
              end
            end
            CMD_LINE: begin
              // equal endpoints take the vertical path
              if (x_start_i == x_end_i) begin
                vert_d  = 1'b1;
                fixed_d = x_start_i;
                k_d     = (y_start_i < y_end_i) ? y_start_i : y_end_i;
                hi_d    = (y_start_i < y_end_i) ? y_end_i : y_start_i;
                state_d = ST_LINE;
              end else if (y_start_i == y_end_i) begin
                vert_d  = 1'b0;
                fixed_d = y_start_i;
                k_d     = (x_start_i < x_end_i) ? x_start_i : x_end_i;
                hi_d    = (x_start_i < x_end_i) ? x_end_i : x_start_i;
                state_d = ST_LINE;
              end else begin
                fin        = 1'b1;
                fin_status = STATUS_DIAG;
              end
            end
            CMD_CLEAR: begin
              clr_cnt_d    = '0;
              clr_report_d = 1'b1;
              state_d      = ST_CLR;
            end
            CMD_READ: begin
              state_d = ST_RDB;
            end
            default: ;
          endcase
        end
      end

      ST_RMW: begin
        mem_we    = 1'b1;
        mem_wdata = on_q ? (rdata_q | bit_mask) : (rdata_q & ~bit_mask);
        if (line_q && (k_q != hi_q)) begin
          k_d     = k_q + COORD_W'(1);
          state_d = ST_LINE;
        end else begin
          fin = 1'b1;
        end
      end

      ST_LINE: begin
        if (pix_ok) begin
          addr_d  = pix_addr;
          bit_d   = py[BIT_W-1:0];
          on_d    = 1'b1;
          line_d  = 1'b1;
          state_d = ST_RMW;
        end else if (k_q == hi_q) begin
          // the inclusive end stops the walk, also at the top of the range
          fin = 1'b1;
        end else begin
          k_d = k_q + COORD_W'(1);
        end
      end

      ST_RDB: begin
        fin      = 1'b1;
        fin_byte = rdata_q;
      end

      ST_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        clr_cnt_d = clr_cnt_q + ADDR_W'(1);
        if (&clr_cnt_q) begin
          // the sweep after reset gives no result word
          if (clr_report_q) begin
            fin = 1'b1;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_POST: begin
        if (slot_free) begin
          out_load    = 1'b1;
          status_d    = res_status_q;
          read_byte_d = res_byte_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (fin) begin
      if (slot_free) begin
        out_load    = 1'b1;
        status_d    = fin_status;
        read_byte_d = fin_byte;
        state_d     = ST_IDLE;
      end else begin
        res_status_d = fin_status;
        res_byte_d   = fin_byte;
        state_d      = ST_POST;
      end
    end

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLR;
      clr_cnt_q    <= '0;
      clr_report_q <= 1'b0;
      out_valid_q  <= 1'b0;
      status_q     <= STATUS_DONE;
      read_byte_q  <= 8'd0;
      line_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_cnt_q    <= clr_cnt_d;
      clr_report_q <= clr_report_d;
      out_valid_q  <= out_valid_d;
      status_q     <= status_d;
      read_byte_q  <= read_byte_d;
      line_q       <= line_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    addr_q       <= addr_d;
    bit_q        <= bit_d;
    on_q         <= on_d;
    vert_q       <= vert_d;
    fixed_q      <= fixed_d;
    k_q          <= k_d;
    hi_q         <= hi_d;
    res_status_q <= res_status_d;
    res_byte_q   <= res_byte_d;
  end

  // frame store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      frame_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= frame_mem[mem_raddr];
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign read_byte_o = read_byte_q;

`ifndef SYNTH
  a_no_write_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> !in_ready_o)
    else $error("store written while a command word can be taken");

  a_rmw_same_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RMW) |-> (mem_waddr == $past(mem_raddr)))
    else $error("write-back address differs from the byte read");

  a_reset_sweep_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_CLR) && !clr_report_q) |-> !out_load)
    else $error("result word produced by the reset clearing pass");

  a_status_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != STATUS_DONE)) |-> (read_byte_o == 8'd0))
    else $error("rejected command carries a nonzero byte");
`endif

endmodule

// ----- bench/mfb_frame_tracker.sv -----
`timescale 1ns / 1ps

module mfb_frame_tracker #(
  parameter int unsigned FRAME_WIDTH  = mfb_pkg::DEF_FRAME_WIDTH,
  parameter int unsigned FRAME_HEIGHT = mfb_pkg::DEF_FRAME_HEIGHT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [1:0]                   cmd_i,
  input  logic [mfb_pkg::COORD_W-1:0]  x_start_i,
  input  logic [mfb_pkg::COORD_W-1:0]  y_start_i,
  input  logic [mfb_pkg::COORD_W-1:0]  x_end_i,
  input  logic [mfb_pkg::COORD_W-1:0]  y_end_i,
  input  logic                         pixel_on_i,
  input  logic [mfb_pkg::ADDR_W-1:0]   byte_index_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [1:0]                   status_i,
  input  logic [7:0]                   read_byte_i,
  output int                           pending_o,
  output int                           fail_count_o
);

  import mfb_pkg::*;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] read_byte;
  } fb_result_t;

  logic [7:0] frame_mem [STORE_DEPTH];
  fb_result_t expected_q [$];
  fb_result_t want;

  function automatic logic [1:0] set_pixel(int unsigned x, int unsigned y, bit on);
    int unsigned addr;
    logic [7:0] mask;
    if (x >= FRAME_WIDTH || y >= FRAME_HEIGHT) return STATUS_OUTSIDE;
    addr = x + (y / PAGE_ROWS) * FRAME_WIDTH;
    if (addr >= STORE_DEPTH) return STATUS_OUTSIDE;
    mask = 8'(1 << (y % PAGE_ROWS));
    if (on) frame_mem[addr] = frame_mem[addr] | mask;
    else frame_mem[addr] = frame_mem[addr] & ~mask;
    return STATUS_DONE;
  endfunction

  // off-frame pixels of a line are skipped, the larger end is inclusive
  function automatic logic [1:0] draw_line(int unsigned x0, int unsigned y0,
                                           int unsigned x1, int unsigned y1);
    int unsigned lo;
    int unsigned hi;
    if (x0 == x1) begin
      lo = (y0 < y1) ? y0 : y1;
      hi = (y0 < y1) ? y1 : y0;
      for (int unsigned k = lo; k <= hi; k++) void'(set_pixel(x0, k, 1'b1));
      return STATUS_DONE;
    end
    if (y0 == y1) begin
      lo = (x0 < x1) ? x0 : x1;
      hi = (x0 < x1) ? x1 : x0;
      for (int unsigned k = lo; k <= hi; k++) void'(set_pixel(k, y0, 1'b1));
      return STATUS_DONE;
    end
    return STATUS_DIAG;
  endfunction

  function automatic fb_result_t apply_command(logic [1:0] cmd, logic [7:0] xs,
                                               logic [7:0] ys, logic [7:0] xe,
                                               logic [7:0] ye, logic on,
                                               logic [8:0] idx);
    fb_result_t res;
    res = '0;
    case (cmd)
      CMD_PIXEL: res.status = set_pixel(32'(xs), 32'(ys), on);
      CMD_LINE:  res.status = draw_line(32'(xs), 32'(ys), 32'(xe), 32'(ye));
      CMD_CLEAR: foreach (frame_mem[i]) frame_mem[i] = '0;
      CMD_READ:  res.read_byte = frame_mem[idx];
      default:   res = '0;
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (frame_mem[i]) frame_mem[i] = '0;
      expected_q.delete();
      fail_count_o = 0;
    end else begin
      // results leave only after their command is taken, as the output is registered, so check first
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("result word with nothing pending: status %0d read_byte 0x%02h",
                 status_i, read_byte_i);
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          if (status_i !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, status_i);
            fail_count_o++;
          end
          if (read_byte_i !== want.read_byte) begin
            $error("read_byte mismatch: expected 0x%02h, got 0x%02h",
                   want.read_byte, read_byte_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        expected_q.push_back(apply_command(cmd_i, x_start_i, y_start_i, x_end_i,
                                           y_end_i, pixel_on_i, byte_index_i));
    end
    pending_o = expected_q.size();
  end

endmodule

// ----- bench/mono_framebuffer_pixel_line_engine_test.sv -----
`timescale 1ns / 1ps

module mono_framebuffer_pixel_line_engine_test;
  import mfb_pkg::*;

  localparam int unsigned FW              = DEF_FRAME_WIDTH;
  localparam int unsigned FH              = DEF_FRAME_HEIGHT;
  // worst case: a clear or a long line per word plus stalls, with a wide margin
  localparam int unsigned CYCLE_LIMIT     = 2_000_000;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned WORDS_PER_PHASE = 160;
  localparam int unsigned HOLD_WORDS      = 30;
  // clear all is the slowest command
  localparam int unsigned TAIL_CYCLES     = 600;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_valid   = 1'b0;
  logic               in_ready;
  logic [1:0]         cmd        = CMD_READ;
  logic [COORD_W-1:0] x_start    = '0;
  logic [COORD_W-1:0] y_start    = '0;
  logic [COORD_W-1:0] x_end      = '0;
  logic [COORD_W-1:0] y_end      = '0;
  logic               pixel_on   = 1'b0;
  logic [ADDR_W-1:0]  byte_index = '0;
  logic               out_valid;
  logic               out_ready  = 1'b0;
  logic [1:0]         status;
  logic [7:0]         read_byte;

  int pending;
  int fails;

  // idling odds in percent, written by the stimulus process only
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  // the receiver serves each new request with one long hold-off
  int unsigned hold_requests = 0;

  // last drawn point, so reads often hit bytes that were touched
  int unsigned last_x = 0;
  int unsigned last_y = 0;

  int unsigned cycle_count = 0;

  mono_framebuffer_pixel_line_engine #(
    .FRAME_WIDTH (FW),
    .FRAME_HEIGHT(FH)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .cmd_i       (cmd),
    .x_start_i   (x_start),
    .y_start_i   (y_start),
    .x_end_i     (x_end),
    .y_end_i     (y_end),
    .pixel_on_i  (pixel_on),
    .byte_index_i(byte_index),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .status_o    (status),
    .read_byte_o (read_byte)
  );

  // watches both channels, predicts each result and counts mismatches
  mfb_frame_tracker #(
    .FRAME_WIDTH (FW),
    .FRAME_HEIGHT(FH)
  ) tracker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .cmd_i       (cmd),
    .x_start_i   (x_start),
    .y_start_i   (y_start),
    .x_end_i     (x_end),
    .y_end_i     (y_end),
    .pixel_on_i  (pixel_on),
    .byte_index_i(byte_index),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .status_i    (status),
    .read_byte_i (read_byte),
    .pending_o   (pending),
    .fail_count_o(fails)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold-off counted here on request
  initial begin
    int unsigned hold_left;
    int unsigned holds_served;
    hold_left = 0;
    holds_served = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_requests != holds_served) begin
        holds_served++;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // offer one command word and hold it until the block takes it;
  // called at a rising edge, returns at the accepting rising edge
  task automatic send_word(logic [1:0] c, logic [7:0] xs, logic [7:0] ys, logic [7:0] xe,
                           logic [7:0] ye, logic on, logic [8:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    cmd        <= c;
    x_start    <= xs;
    y_start    <= ys;
    x_end      <= xe;
    y_end      <= ye;
    pixel_on   <= on;
    byte_index <= idx;
    in_valid   <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid and wait until every expected result word has arrived
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // mostly short spans so lines stay cheap, now and then a long one
  function automatic int unsigned line_far_end(int unsigned a);
    int unsigned span;
    span = ($urandom_range(99) < 80) ? $urandom_range(15) : $urandom_range(255);
    if ($urandom_range(1)) return (a + span > 255) ? 255 : a + span;
    return (a < span) ? 0 : a - span;
  endfunction

  function automatic int unsigned pick_col();
    return ($urandom_range(99) < 85) ? $urandom_range(FW - 1) : $urandom_range(255);
  endfunction

  function automatic int unsigned pick_row();
    return ($urandom_range(99) < 85) ? $urandom_range(FH - 1) : $urandom_range(255);
  endfunction

  task automatic send_random_word();
    int unsigned pick;
    int unsigned shape;
    int unsigned xs;
    int unsigned ys;
    int unsigned xe;
    int unsigned ye;
    int unsigned idx;
    logic [1:0] c;
    pick  = $urandom_range(99);
    shape = $urandom_range(99);
    // unused fields carry random noise
    xs  = $urandom_range(255);
    ys  = $urandom_range(255);
    xe  = $urandom_range(255);
    ye  = $urandom_range(255);
    idx = $urandom_range(STORE_DEPTH - 1);
    if (pick < 34) begin
      c  = CMD_PIXEL;
      xs = pick_col();
      ys = pick_row();
      last_x = xs;
      last_y = ys;
    end else if (pick < 60) begin
      c = CMD_LINE;
      if (shape < 40) begin
        // horizontal
        ys = pick_row();
        ye = ys;
        xs = pick_col();
        xe = line_far_end(xs);
      end else if (shape < 80) begin
        // vertical
        xs = pick_col();
        xe = xs;
        ys = pick_row();
        ye = line_far_end(ys);
      end
      last_x = xs;
      last_y = ys;
    end else if (pick < 97) begin
      c = CMD_READ;
      if (shape < 40) idx = (last_x + (last_y / PAGE_ROWS) * FW) % STORE_DEPTH;
    end else begin
      c = CMD_CLEAR;
    end
    send_word(c, 8'(xs), 8'(ys), 8'(xe), 8'(ye), 1'($urandom_range(1)), 9'(idx));
  endtask

  initial begin
    int unsigned send_pct [4];
    int unsigned recv_pct [4];
    send_pct = '{0, 45, 0, 11};
    recv_pct = '{0, 0, 45, 11};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    // the clearing pass after reset holds off the first word by itself
    @(posedge clk);

    // directed words: blank read, corners, outside pixels, clear bit
    send_word(CMD_READ,  0,   0,   0,   0,   1'b0, 0);
    send_word(CMD_PIXEL, 0,   0,   0,   0,   1'b1, 0);
    send_word(CMD_READ,  0,   0,   0,   0,   1'b0, 0);
    send_word(CMD_PIXEL, 127, 31,  0,   0,   1'b1, 0);
    send_word(CMD_READ,  0,   0,   0,   0,   1'b0, 511);
    send_word(CMD_PIXEL, 128, 0,   0,   0,   1'b1, 0);
    send_word(CMD_PIXEL, 0,   32,  0,   0,   1'b1, 0);
    send_word(CMD_PIXEL, 255, 255, 255, 255, 1'b1, 511);
    send_word(CMD_PIXEL, 0,   0,   0,   0,   1'b0, 0);
    send_word(CMD_READ,  0,   0,   0,   0,   1'b0, 0);
    // horizontal line running off the right edge up to 255
    send_word(CMD_LINE,  120, 5,   255, 5,   1'b0, 0);
    send_word(CMD_READ,  0,   0,   0,   0,   1'b0, 127);
    // vertical line given from the far end, ending at 255
    send_word(CMD_LINE,  3,   255, 3,   0,   1'b0, 0);
    send_word(CMD_READ,  0,   0,   0,   0,   1'b0, 387);
    // equal endpoints set one pixel
    send_word(CMD_LINE,  10,  10,  10,  10,  1'b0, 0);
    send_word(CMD_READ,  0,   0,   0,   0,   1'b0, 138);
    // diagonal is rejected
    send_word(CMD_LINE,  0,   0,   5,   5,   1'b1, 0);
    send_word(CMD_READ,  0,   0,   0,   0,   1'b0, 0);
    // lines entirely off frame
    send_word(CMD_LINE,  200, 0,   200, 31,  1'b0, 0);
    send_word(CMD_LINE,  255, 255, 0,   255, 1'b0, 0);
    send_word(CMD_READ,  0,   0,   0,   0,   1'b0, 511);
    send_word(CMD_CLEAR, 255, 255, 255, 255, 1'b1, 511);
    send_word(CMD_READ,  0,   0,   0,   0,   1'b0, 387);
    send_word(CMD_READ,  0,   0,   0,   0,   1'b0, 127);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = send_pct[p];
      recv_stall_pct = recv_pct[p];
      repeat (WORDS_PER_PHASE) send_random_word();
      if (p == 0) begin
        // long receiver hold-off while words keep coming, so the input backs up
        hold_requests++;
        repeat (HOLD_WORDS) send_random_word();
        wait_drained();
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/mfb_pkg.sv
hw/rtl/mono_framebuffer_pixel_line_engine.sv
bench/mfb_frame_tracker.sv
bench/mono_framebuffer_pixel_line_engine_test.sv
